// File: rtl/core/lidar_point_cluster_tracker_top_macros.svh
// ---------------------------------------------------------------------------
// Lidar point cluster tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LIDAR_POINT_CLUSTER_TRACKER_TOP_MACROS_SVH
`define LIDAR_POINT_CLUSTER_TRACKER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lpct_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lidar point cluster tracker package
// Sizes, request codes, sequencer states and the structs between modules.
// ---------------------------------------------------------------------------
package lpct_pkg;

  // Slot table size.
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths.
  localparam int OBS_W  = 12;
  localparam int CNT_W  = 16;
  localparam int TIME_W = 32;
  localparam int POS_W  = 16;

  // Arithmetic widths: 18x18 signed multiplier, 33-bit numerator,
  // 32-bit magnitude, 17-bit divisor, 16 quotient bits.
  localparam int MUL_W     = 18;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIST_W    = 34;
  localparam int LIM2_W    = 28;
  localparam int NUM_W     = 33;
  localparam int MAG_W     = 32;
  localparam int DVS_W     = 17;
  localparam int DIV_STEPS = 16;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [OBS_W-1:0] OBS_RESET = 12'd200;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  // Request codes.
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LIM,
    S_DX,
    S_DY,
    S_CMP,
    S_MUL,
    S_ADD,
    S_ABS,
    S_DIV,
    S_REP,
    S_RES
  } state_t;

  // One cluster slot.
  typedef struct packed {
    logic        [CNT_W-1:0]  cnt;
    logic        [TIME_W-1:0] tstamp;
    logic signed [POS_W-1:0]  mean_x;
    logic signed [POS_W-1:0]  mean_y;
  } slot_t;

  // Slot store write request.
  typedef struct packed {
    logic              clear;
    logic [SLOT_W-1:0] idx;
    logic              we_cnt;
    logic              we_time;
    logic              we_mx;
    logic              we_my;
    slot_t             data;
  } slot_wr_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_STEPS-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/core/lpct_slot_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lidar point cluster tracker slot store
// Register file of cluster slots with one read port and a whole-table clear.
// ---------------------------------------------------------------------------
module lpct_slot_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lpct_pkg::slot_wr_t        wr,
  input  logic [lpct_pkg::SLOT_W-1:0] rd_idx,
  output lpct_pkg::slot_t           rd
);
  import lpct_pkg::*;

  logic        [CNT_W-1:0]  cnt_r  [SLOTS];
  logic        [TIME_W-1:0] time_r [SLOTS];
  logic signed [POS_W-1:0]  mx_r   [SLOTS];
  logic signed [POS_W-1:0]  my_r   [SLOTS];

  // Reset and the clear request empty every slot; otherwise write by field.
  always_ff @(posedge clk) begin
    if (!rst_n || wr.clear) begin
      for (int i = 0; i < SLOTS; i++) begin
        cnt_r[i]  <= '0;
        time_r[i] <= '0;
        mx_r[i]   <= '0;
        my_r[i]   <= '0;
      end
    end else begin
      if (wr.we_cnt)  cnt_r[wr.idx]  <= wr.data.cnt;
      if (wr.we_time) time_r[wr.idx] <= wr.data.tstamp;
      if (wr.we_mx)   mx_r[wr.idx]   <= wr.data.mean_x;
      if (wr.we_my)   my_r[wr.idx]   <= wr.data.mean_y;
    end
  end

  // Single read port.
  always_comb begin
    rd.cnt    = cnt_r[rd_idx];
    rd.tstamp = time_r[rd_idx];
    rd.mean_x = mx_r[rd_idx];
    rd.mean_y = my_r[rd_idx];
  end

endmodule

// File: rtl/core/lpct_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lidar point cluster tracker divider
// Restoring unsigned divider giving one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lpct_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  lpct_pkg::div_req_t req,
  output lpct_pkg::div_rsp_t rsp
);
  import lpct_pkg::*;

  logic [MAG_W-1:0]     rem_r, rem_nxt;
  logic [MAG_W-1:0]     dsh_r, dsh_nxt;
  logic [DIV_STEPS-1:0] quot_r, quot_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic                 ge;

  // The quotient is known to fit in DIV_STEPS bits, so the divisor starts
  // shifted up by DIV_STEPS-1 places and walks down one place a cycle.
  always_comb begin
    ge       = (rem_r >= dsh_r);
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.dividend;
      dsh_nxt  = {req.divisor, {(DIV_STEPS-1){1'b0}}};
      quot_nxt = '0;
      step_nxt = STEP_W'(DIV_STEPS);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (ge) rem_nxt = rem_r - dsh_r;
      quot_nxt = {quot_r[DIV_STEPS-2:0], ge};
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// File: rtl/core/lpct_ctrl.sv
`timescale 1ns / 1ps
`include "lidar_point_cluster_tracker_top_macros.svh"
// ---------------------------------------------------------------------------
// Lidar point cluster tracker sequencer
// Walks the slots with one shared multiplier and drives the divider.
// ---------------------------------------------------------------------------
module lpct_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [1:0]                  func,
  input  logic [lpct_pkg::TIME_W-1:0] sample_time_ms,
  input  logic signed [lpct_pkg::POS_W-1:0] sample_x_qmm,
  input  logic signed [lpct_pkg::POS_W-1:0] sample_y_qmm,
  input  logic [lpct_pkg::OBS_W-1:0]  join_dist_mm,
  output logic                        busy,
  output lpct_pkg::slot_wr_t          wr,
  output logic [lpct_pkg::SLOT_W-1:0] rd_idx,
  input  lpct_pkg::slot_t             rd,
  output lpct_pkg::div_req_t          div_req,
  input  lpct_pkg::div_rsp_t          div_rsp,
  output logic                        rep_fire
);
  import lpct_pkg::*;

  state_t                   state_r, state_nxt;
  logic [SLOT_W-1:0]        idx_r, idx_nxt;
  logic [SLOT_W-1:0]        best_r, best_nxt;
  logic [CNT_W-1:0]         most_r, most_nxt;
  logic [TIME_W-1:0]        t_r, t_nxt;
  logic signed [POS_W-1:0]  x_r, x_nxt;
  logic signed [POS_W-1:0]  y_r, y_nxt;
  logic [LIM2_W-1:0]        lim2_r, lim2_nxt;
  logic [DIST_W-1:0]        acc_r, acc_nxt;
  logic signed [NUM_W-1:0]  num_r, num_nxt;
  logic                     neg_r, neg_nxt;
  logic                     axis_r, axis_nxt;

  logic signed [POS_W:0]    dx, dy;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [POS_W-1:0]  mean_sel, samp_sel, mean_new;
  logic                     last, join_hit;

  // Slot position minus sample position, axis selects, the end-of-table flag, the join test and the new mean.
  always_comb begin
    dx       = $signed({rd.mean_x[POS_W-1], rd.mean_x}) - $signed({x_r[POS_W-1], x_r});
    dy       = $signed({rd.mean_y[POS_W-1], rd.mean_y}) - $signed({y_r[POS_W-1], y_r});
    mean_sel = axis_r ? rd.mean_y : rd.mean_x;
    samp_sel = axis_r ? y_r : x_r;
    last     = (idx_r == SLOT_W'(SLOTS - 1));
    join_hit = (acc_r < {{(DIST_W-LIM2_W){1'b0}}, lim2_r});
    mean_new = neg_r ? POS_W'(-$signed({1'b0, div_rsp.quot}))
                     : $signed(div_rsp.quot);
  end

  // Shared multiplier: join limit squared, dx squared, dy squared, n*mean.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LIM: begin
        mul_a = $signed({4'b0, join_dist_mm, 2'b0});
        mul_b = $signed({4'b0, join_dist_mm, 2'b0});
      end
      S_DX: begin
        mul_a = $signed({dx[POS_W], dx});
        mul_b = $signed({dx[POS_W], dx});
      end
      S_DY: begin
        mul_a = $signed({dy[POS_W], dy});
        mul_b = $signed({dy[POS_W], dy});
      end
      S_MUL: begin
        mul_a = $signed({2'b0, rd.cnt});
        mul_b = $signed({{(MUL_W-POS_W){mean_sel[POS_W-1]}}, mean_sel});
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && func == FUNC_ADD)    state_nxt = S_LIM;
        if (start && func == FUNC_REPORT) state_nxt = S_REP;
      end
      S_LIM: state_nxt = S_DX;
      S_DX:  state_nxt = (rd.cnt == '0) ? S_IDLE : S_DY;
      S_DY:  state_nxt = S_CMP;
      S_CMP: begin
        if (join_hit)  state_nxt = S_MUL;
        else if (last) state_nxt = S_IDLE;
        else           state_nxt = S_DX;
      end
      S_MUL: state_nxt = S_ADD;
      S_ADD: state_nxt = S_ABS;
      S_ABS: state_nxt = S_DIV;
      S_DIV: begin
        if (div_rsp.done) state_nxt = axis_r ? S_IDLE : S_MUL;
      end
      S_REP: state_nxt = last ? S_RES : S_REP;
      S_RES: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    idx_nxt  = idx_r;
    best_nxt = best_r;
    most_nxt = most_r;
    t_nxt    = t_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    lim2_nxt = lim2_r;
    acc_nxt  = acc_r;
    num_nxt  = num_r;
    neg_nxt  = neg_r;
    axis_nxt = axis_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          t_nxt    = sample_time_ms;
          x_nxt    = sample_x_qmm;
          y_nxt    = sample_y_qmm;
          idx_nxt  = '0;
          best_nxt = '0;
          most_nxt = '0;
          axis_nxt = 1'b0;
        end
      end
      S_LIM: lim2_nxt = mul_p[LIM2_W-1:0];
      S_DX:  acc_nxt  = mul_p[DIST_W-1:0];
      S_DY:  acc_nxt  = acc_r + mul_p[DIST_W-1:0];
      S_CMP: begin
        if (!join_hit && !last) idx_nxt = idx_r + SLOT_W'(1);
      end
      S_MUL: num_nxt = mul_p[NUM_W-1:0];
      S_ADD: num_nxt = num_r + $signed({{(NUM_W-POS_W){samp_sel[POS_W-1]}}, samp_sel});
      S_ABS: neg_nxt = num_r[NUM_W-1];
      S_DIV: begin
        if (div_rsp.done && !axis_r) axis_nxt = 1'b1;
      end
      S_REP: begin
        if (rd.cnt > most_r) begin
          most_nxt = rd.cnt;
          best_nxt = idx_r;
        end
        if (!last) idx_nxt = idx_r + SLOT_W'(1);
      end
      default: ;
    endcase
  end

  // Outputs: store writes, divider request, report strobe.
  always_comb begin
    busy     = (state_r != S_IDLE);
    rep_fire = (state_r == S_RES);
    rd_idx   = (state_r == S_RES) ? best_r : idx_r;
    wr       = '0;
    wr.idx   = idx_r;
    div_req  = '0;
    div_req.divisor = {1'b0, rd.cnt} + DVS_W'(1);
    div_req.dividend = num_r[NUM_W-1] ? MAG_W'(-num_r) : num_r[MAG_W-1:0];
    case (state_r)
      S_IDLE: wr.clear = start && (func == FUNC_CLEAR);
      S_DX: begin
        // An empty slot is seeded with the sample.
        if (rd.cnt == '0) begin
          wr.we_cnt      = 1'b1;
          wr.we_time     = 1'b1;
          wr.we_mx       = 1'b1;
          wr.we_my       = 1'b1;
          wr.data.cnt    = CNT_W'(1);
          wr.data.tstamp = t_r;
          wr.data.mean_x = x_r;
          wr.data.mean_y = y_r;
        end
      end
      S_ABS: div_req.start = 1'b1;
      S_DIV: begin
        // Write back each axis mean; count and time follow with the second.
        if (div_rsp.done) begin
          wr.we_mx       = !axis_r;
          wr.we_my       = axis_r;
          wr.we_cnt      = axis_r;
          wr.we_time     = axis_r;
          wr.data.mean_x = mean_new;
          wr.data.mean_y = mean_new;
          wr.data.cnt    = (rd.cnt == CNT_MAX) ? rd.cnt : rd.cnt + CNT_W'(1);
          wr.data.tstamp = (rd.tstamp < t_r) ? t_r : rd.tstamp;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      axis_r  <= axis_nxt;
    end
    best_r <= best_nxt;
    most_r <= most_nxt;
    t_r    <= t_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    lim2_r <= lim2_nxt;
    acc_r  <= acc_nxt;
    num_r  <= num_nxt;
    neg_r  <= neg_nxt;
  end

  // Checks on the sequencer.
  `LPCT_ASSERT_NEXT(a_add_starts, state_r == S_IDLE && start && func == FUNC_ADD, state_r == S_LIM, "add request did not start the slot walk")
  `LPCT_ASSERT_IMPL(a_join_nonempty, state_r == S_MUL, rd.cnt != '0, "joining an empty slot")
  `LPCT_ASSERT_IMPL(a_quot_range, state_r == S_DIV && div_rsp.done && !neg_r, !div_rsp.quot[DIV_STEPS-1], "mean quotient out of range")
  `LPCT_ASSERT_IMPL(a_done_in_div, div_rsp.done, state_r == S_DIV, "divider finished outside the divide state")

endmodule

// File: rtl/core/lidar_point_cluster_tracker_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lidar point cluster tracker
// Leader clustering of range-sensor points with a running mean per slot.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An add or report
// request keeps the block busy until it is done; a clear request empties the
// table without raising busy. An add request squares the join limit, then for
// each slot it visits squares dx and dy on the shared multiplier and compares
// the sum with the limit, and, when it joins a slot, makes two passes (multiply,
// add, magnitude, sixteen divider steps) for the x and y means. A report
// request walks all 16 slots at one per cycle, then reads the chosen slot and
// shows its result in the same cycle in which busy falls. out_strobe is high
// for exactly one cycle to mark the result, which the out_ ports hold until
// the next report, and the receiver cannot hold it off.
// ---------------------------------------------------------------------------
module lidar_point_cluster_tracker_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_func,
  input  logic [lpct_pkg::TIME_W-1:0]        in_sample_time_ms,
  input  logic signed [lpct_pkg::POS_W-1:0]  in_sample_x_qmm,
  input  logic signed [lpct_pkg::POS_W-1:0]  in_sample_y_qmm,
  output logic                               out_strobe,
  output logic [lpct_pkg::CNT_W-1:0]         out_best_count,
  output logic [lpct_pkg::TIME_W-1:0]        out_best_time_ms,
  output logic signed [lpct_pkg::POS_W-1:0]  out_best_x_qmm,
  output logic signed [lpct_pkg::POS_W-1:0]  out_best_y_qmm,
  input  logic                               cfg_we,
  input  logic [lpct_pkg::OBS_W-1:0]         cfg_wdata
);
  import lpct_pkg::*;

  logic [OBS_W-1:0]  obs_r;
  logic              strobe_r;
  slot_t             res_r;
  slot_wr_t          wr;
  slot_t             rd;
  logic [SLOT_W-1:0] rd_idx;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              rep_fire;

  // Obstacle size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_r <= OBS_RESET;
    end else if (cfg_we) begin
      obs_r <= cfg_wdata;
    end
  end

  lpct_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .func             (in_func),
    .sample_time_ms   (in_sample_time_ms),
    .sample_x_qmm     (in_sample_x_qmm),
    .sample_y_qmm     (in_sample_y_qmm),
    .join_dist_mm     (obs_r),
    .busy             (busy),
    .wr               (wr),
    .rd_idx           (rd_idx),
    .rd               (rd),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .rep_fire         (rep_fire)
  );

  lpct_slot_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd     (rd)
  );

  lpct_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Result register: the chosen slot is captured when the report completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= rep_fire;
    end
    if (rep_fire) res_r <= rd;
  end

  assign out_strobe       = strobe_r;
  assign out_best_count   = res_r.cnt;
  assign out_best_time_ms = res_r.tstamp;
  assign out_best_x_qmm   = res_r.mean_x;
  assign out_best_y_qmm   = res_r.mean_y;

endmodule
